// ===== hdl/hvf_pkg.sv =====
// Shared widths and types for the haptic velocity filter and force block.
// No dependencies; hvf_mac, hvf_core and the top level take their names from here.
`default_nettype none

package hvf_pkg;

    localparam int POS_W   = 32;
    localparam int TAP_W   = 40;
    localparam int COEF_W  = 34;
    localparam int CHUNK_W = 25;
    localparam int PROD_W  = COEF_W + CHUNK_W;
    localparam int ACC_W   = 80;
    localparam int LO_W    = 16;
    localparam int RND_SH  = 30;
    localparam int AXES    = 3;

    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(64'd536870912);

    typedef struct packed {
        logic                      load;
        logic                      round;
        logic                      mul_en;
        logic                      hi;
        logic signed [COEF_W-1:0]  coef;
        logic signed [CHUNK_W-1:0] chunk;
    } mac_ctl_t;

    typedef struct packed {
        logic [AXES-1:0][POS_W-1:0] pos;
        logic [AXES-1:0][POS_W-1:0] cmd;
        logic [AXES-1:0][POS_W:0]   diff;
        logic                       locked;
        logic                       enabled;
    } item_t;

    typedef struct packed {
        logic [AXES-1:0][POS_W-1:0] vel;
        logic [AXES-1:0][POS_W-1:0] frc;
    } res_t;

    typedef struct packed {
        logic start;
        logic take;
    } core_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

endpackage

`default_nettype wire

// ===== hdl/hvf_mac.sv =====
// Shared multiply-accumulate unit: one registered 34 x 25 product, then an
// 80-bit accumulator with an optional 16-bit shift. Depends on hvf_pkg.
`default_nettype none

module hvf_mac (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hvf_pkg::mac_ctl_t                   ctl,
    output logic signed [hvf_pkg::ACC_W-1:0]         acc
);

    logic signed [hvf_pkg::PROD_W-1:0] prod_reg;
    logic signed [hvf_pkg::PROD_W-1:0] prod_next;
    logic                              prod_hi_reg;
    logic                              prod_vld_reg;
    logic signed [hvf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [hvf_pkg::ACC_W-1:0]  acc_next;
    logic signed [hvf_pkg::PROD_W-1:0] coef_ext;
    logic signed [hvf_pkg::PROD_W-1:0] chunk_ext;
    logic signed [hvf_pkg::ACC_W-1:0]  prod_ext;
    logic signed [hvf_pkg::ACC_W-1:0]  addend;

    always_comb
    begin
        coef_ext  = hvf_pkg::PROD_W'($signed(ctl.coef));
        chunk_ext = hvf_pkg::PROD_W'($signed(ctl.chunk));
        prod_next = coef_ext * chunk_ext;
        prod_ext  = hvf_pkg::ACC_W'(prod_reg);
        addend    = prod_hi_reg ? (prod_ext <<< hvf_pkg::LO_W) : prod_ext;
        priority if (ctl.load)
        begin
            acc_next = ctl.round ? $signed(hvf_pkg::HALF_LSB) : '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + addend;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg    <= prod_next;
            prod_hi_reg <= ctl.hi;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/hvf_core.sv =====
// Sequencer, filter state and operand selection around the shared MAC.
// Depends on hvf_pkg and hvf_mac.
`default_nettype none

module hvf_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire hvf_pkg::core_ctl_t    ctl,
    input  wire hvf_pkg::item_t        item,
    input  wire logic [1:0]            units,
    output hvf_pkg::core_stat_t        stat,
    output hvf_pkg::res_t              res
);

    localparam int TAP_W  = hvf_pkg::TAP_W;
    localparam int POS_W  = hvf_pkg::POS_W;
    localparam int ACC_W  = hvf_pkg::ACC_W;
    localparam int COEF_W = hvf_pkg::COEF_W;

    localparam logic [3:0] TERM_POS    = 4'd0;
    localparam logic [3:0] TERM_POS1   = 4'd1;
    localparam logic [3:0] TERM_POS2   = 4'd2;
    localparam logic [3:0] TERM_X0     = 4'd3;
    localparam logic [3:0] TERM_RAW0   = 4'd4;
    localparam logic [3:0] TERM_RAW1   = 4'd5;
    localparam logic [3:0] TERM_RAW2   = 4'd6;
    localparam logic [3:0] TERM_FILT0  = 4'd7;
    localparam logic [3:0] TERM_FILT1  = 4'd8;
    localparam logic [3:0] TERM_FILT2  = 4'd9;
    localparam logic [3:0] TERM_SPRING = 4'd10;
    localparam logic [3:0] TERM_DAMP   = 4'd11;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    localparam logic [1:0] UNITS_MM = 2'd0;
    localparam logic [1:0] UNITS_CM = 2'd1;
    localparam logic [1:0] UNITS_DM = 2'd2;
    localparam logic [1:0] UNITS_M  = 2'd3;

    localparam logic signed [COEF_W-1:0] C_POS    = 34'sd1500;
    localparam logic signed [COEF_W-1:0] C_POS1   = -34'sd2000;
    localparam logic signed [COEF_W-1:0] C_POS2   = 34'sd500;
    localparam logic signed [COEF_W-1:0] C_B0     = 34'sd235794;
    localparam logic signed [COEF_W-1:0] C_B1     = 34'sd707381;
    localparam logic signed [COEF_W-1:0] C_A1     = 34'sd2951501526;
    localparam logic signed [COEF_W-1:0] C_A2     = -34'sd2714634079;
    localparam logic signed [COEF_W-1:0] C_A3     = 34'sd834941642;
    localparam logic signed [COEF_W-1:0] C_UNITY  = 34'sd1073741824;
    localparam logic signed [COEF_W-1:0] C_DAMP_N = -34'sd1073742;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    function automatic logic signed [COEF_W-1:0] spring_coef(input logic [1:0] u);
        logic signed [COEF_W-1:0] c;
        unique case (u)
            UNITS_MM: c = 34'sd42949673;
            UNITS_CM: c = 34'sd4294967;
            UNITS_DM: c = 34'sd429497;
            UNITS_M:  c = 34'sd42950;
            default:  c = 34'sd42949673;
        endcase
        return c;
    endfunction

    function automatic logic [TAP_W-1:0] sat_tap(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-TAP_W:0] upper;
        upper = v[ACC_W-1:TAP_W-1];
        if ((upper == '0) || (upper == '1))
            return v[TAP_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(TAP_W-1){1'b0}}};
        else
            return {1'b0, {(TAP_W-1){1'b1}}};
    endfunction

    function automatic logic [POS_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-POS_W:0] upper;
        upper = v[ACC_W-1:POS_W-1];
        if ((upper == '0) || (upper == '1))
            return v[POS_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(POS_W-1){1'b0}}};
        else
            return {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [3:0] term_reg, term_next;
    logic       chunk_reg, chunk_next;

    logic [TAP_W-1:0] x0_reg;
    logic [TAP_W-1:0] y_reg;
    logic [POS_W-1:0] pos1_reg [hvf_pkg::AXES];
    logic [POS_W-1:0] pos2_reg [hvf_pkg::AXES];
    logic [TAP_W-1:0] raw0_reg [hvf_pkg::AXES];
    logic [TAP_W-1:0] raw1_reg [hvf_pkg::AXES];
    logic [TAP_W-1:0] raw2_reg [hvf_pkg::AXES];
    logic [TAP_W-1:0] filt0_reg [hvf_pkg::AXES];
    logic [TAP_W-1:0] filt1_reg [hvf_pkg::AXES];
    logic [TAP_W-1:0] filt2_reg [hvf_pkg::AXES];
    hvf_pkg::res_t    res_reg;

    hvf_pkg::mac_ctl_t        mac_ctl;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [ACC_W-1:0]  y_ext;
    logic [TAP_W-1:0]         opnd;
    logic signed [COEF_W-1:0] coef;
    logic                     term_last;
    logic                     x0_wr;
    logic                     y_wr;
    logic                     axis_wr;

    hvf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .acc   (acc)
    );

    assign acc_rnd = acc >>> hvf_pkg::RND_SH;
    assign y_ext   = ACC_W'($signed(y_reg));

    always_comb
    begin
        unique case (term_reg)
            TERM_POS:
            begin
                coef = C_POS;
                opnd = TAP_W'($signed(item.pos[axis_reg]));
            end
            TERM_POS1:
            begin
                coef = C_POS1;
                opnd = TAP_W'($signed(pos1_reg[axis_reg]));
            end
            TERM_POS2:
            begin
                coef = C_POS2;
                opnd = TAP_W'($signed(pos2_reg[axis_reg]));
            end
            TERM_X0:
            begin
                coef = C_B0;
                opnd = x0_reg;
            end
            TERM_RAW0:
            begin
                coef = C_B1;
                opnd = raw0_reg[axis_reg];
            end
            TERM_RAW1:
            begin
                coef = C_B1;
                opnd = raw1_reg[axis_reg];
            end
            TERM_RAW2:
            begin
                coef = C_B0;
                opnd = raw2_reg[axis_reg];
            end
            TERM_FILT0:
            begin
                coef = C_A1;
                opnd = filt0_reg[axis_reg];
            end
            TERM_FILT1:
            begin
                coef = C_A2;
                opnd = filt1_reg[axis_reg];
            end
            TERM_FILT2:
            begin
                coef = C_A3;
                opnd = filt2_reg[axis_reg];
            end
            TERM_SPRING:
            begin
                coef = item.locked ? spring_coef(units) : C_UNITY;
                opnd = item.locked ? TAP_W'($signed(item.diff[axis_reg]))
                                   : TAP_W'($signed(item.cmd[axis_reg]));
            end
            TERM_DAMP:
            begin
                coef = C_DAMP_N;
                opnd = item.locked ? y_reg : filt0_reg[axis_reg];
            end
            default:
            begin
                coef = '0;
                opnd = '0;
            end
        endcase
    end

    assign term_last = (term_reg == TERM_POS2) || (term_reg == TERM_FILT2) ||
                       (term_reg == TERM_DAMP);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        term_next      = term_reg;
        chunk_next     = chunk_reg;
        x0_wr          = 1'b0;
        y_wr           = 1'b0;
        axis_wr        = 1'b0;
        mac_ctl.load   = 1'b0;
        mac_ctl.round  = 1'b0;
        mac_ctl.mul_en = 1'b0;
        mac_ctl.hi     = chunk_reg;
        mac_ctl.coef   = coef;
        mac_ctl.chunk  = chunk_reg ? {opnd[TAP_W-1], opnd[TAP_W-1:hvf_pkg::LO_W]}
                                   : {(hvf_pkg::CHUNK_W-hvf_pkg::LO_W)'(0),
                                      opnd[hvf_pkg::LO_W-1:0]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next   = S_ISSUE;
                    axis_next    = '0;
                    term_next    = TERM_POS;
                    chunk_next   = 1'b0;
                    mac_ctl.load = 1'b1;
                end
            end
            S_ISSUE:
            begin
                mac_ctl.mul_en = 1'b1;
                if (chunk_reg)
                begin
                    chunk_next = 1'b0;
                    if (term_last)
                        state_next = S_DRAIN;
                    else
                        term_next = term_reg + 4'd1;
                end
                else
                begin
                    chunk_next = 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                priority if (term_reg == TERM_POS2)
                begin
                    x0_wr         = 1'b1;
                    mac_ctl.load  = 1'b1;
                    mac_ctl.round = 1'b1;
                    term_next     = term_reg + 4'd1;
                    state_next    = S_ISSUE;
                end
                else if (term_reg == TERM_FILT2)
                begin
                    y_wr          = 1'b1;
                    mac_ctl.load  = 1'b1;
                    mac_ctl.round = 1'b1;
                    term_next     = term_reg + 4'd1;
                    state_next    = S_ISSUE;
                end
                else
                begin
                    axis_wr = 1'b1;
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        axis_next    = axis_reg + 2'd1;
                        term_next    = TERM_POS;
                        mac_ctl.load = 1'b1;
                        state_next   = S_ISSUE;
                    end
                end
            end
            S_DONE:
            begin
                if (ctl.take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            term_reg  <= TERM_POS;
            chunk_reg <= 1'b0;
            for (int a = 0; a < hvf_pkg::AXES; a++)
            begin
                pos1_reg[a]  <= '0;
                pos2_reg[a]  <= '0;
                raw0_reg[a]  <= '0;
                raw1_reg[a]  <= '0;
                raw2_reg[a]  <= '0;
                filt0_reg[a] <= '0;
                filt1_reg[a] <= '0;
                filt2_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            term_reg  <= term_next;
            chunk_reg <= chunk_next;
            if (axis_wr)
            begin
                pos2_reg[axis_reg]  <= pos1_reg[axis_reg];
                pos1_reg[axis_reg]  <= item.pos[axis_reg];
                raw2_reg[axis_reg]  <= raw1_reg[axis_reg];
                raw1_reg[axis_reg]  <= raw0_reg[axis_reg];
                raw0_reg[axis_reg]  <= x0_reg;
                filt2_reg[axis_reg] <= filt1_reg[axis_reg];
                filt1_reg[axis_reg] <= filt0_reg[axis_reg];
                filt0_reg[axis_reg] <= y_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (x0_wr)
            x0_reg <= sat_tap(acc);
        if (y_wr)
            y_reg <= sat_tap(acc_rnd);
        if (axis_wr)
        begin
            res_reg.vel[axis_reg] <= sat_word(y_ext);
            res_reg.frc[axis_reg] <= item.enabled ? sat_word(acc_rnd) : '0;
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== hdl/haptic_velocity_filter_force_top.sv =====
// A tick runs three axes of twelve products, each in two halves, on the single
// shared MAC; no new word is accepted until the previous result has been taken
// into the output register.
// Reset (rst_n, asynchronous, active low) clears the filter taps, button
// history, lock flag and unit select, sets force enable and empties the output.
`default_nettype none

module haptic_velocity_filter_force_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic               button_grey,
    input  wire logic               button_white,
    input  wire logic signed [31:0] cmd_force_x,
    input  wire logic signed [31:0] cmd_force_y,
    input  wire logic signed [31:0] cmd_force_z,
    input  wire logic signed [31:0] lock_target_x,
    input  wire logic signed [31:0] lock_target_y,
    input  wire logic signed [31:0] lock_target_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      vel_z,
    output logic signed [31:0]      force_x,
    output logic signed [31:0]      force_y,
    output logic signed [31:0]      force_z,
    output logic                    locked,
    output logic                    force_enabled,
    output logic                    button_change
);

    logic [1:0]          units_reg;
    logic [1:0]          prev_btn_reg;
    logic                lock_flag_reg;
    logic                enable_flag_reg;
    hvf_pkg::item_t      item_reg;
    hvf_pkg::item_t      item_next;
    logic                event_item_reg;
    logic                out_valid_reg;
    hvf_pkg::res_t       out_res_reg;
    logic                out_locked_reg;
    logic                out_enabled_reg;
    logic                out_event_reg;

    hvf_pkg::core_ctl_t  cctl;
    hvf_pkg::core_stat_t cstat;
    hvf_pkg::res_t       cres;
    logic                accept;
    logic [1:0]          btn_cur;
    logic                btn_event;

    assign in_ready  = cstat.idle;
    assign accept    = in_valid && in_ready;
    assign btn_cur   = {button_white, button_grey};
    assign btn_event = (btn_cur != prev_btn_reg);

    assign cctl.start = accept;
    assign cctl.take  = cstat.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        item_next.pos[0]  = pos_x;
        item_next.pos[1]  = pos_y;
        item_next.pos[2]  = pos_z;
        item_next.cmd[0]  = cmd_force_x;
        item_next.cmd[1]  = cmd_force_y;
        item_next.cmd[2]  = cmd_force_z;
        item_next.diff[0] = {lock_target_x[31], lock_target_x} - {pos_x[31], pos_x};
        item_next.diff[1] = {lock_target_y[31], lock_target_y} - {pos_y[31], pos_y};
        item_next.diff[2] = {lock_target_z[31], lock_target_z} - {pos_z[31], pos_z};
        item_next.locked  = lock_flag_reg;
        item_next.enabled = enable_flag_reg;
    end

    hvf_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .item  (item_reg),
        .units (units_reg),
        .stat  (cstat),
        .res   (cres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg       <= '0;
            prev_btn_reg    <= '0;
            lock_flag_reg   <= 1'b0;
            enable_flag_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                units_reg <= cfg_wr_data;
            if (accept && btn_event)
            begin
                prev_btn_reg    <= btn_cur;
                enable_flag_reg <= enable_flag_reg ^ button_grey;
                lock_flag_reg   <= lock_flag_reg ^ button_white;
            end
            if (cctl.take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg       <= item_next;
            event_item_reg <= btn_event;
        end
        if (cctl.take)
        begin
            out_res_reg     <= cres;
            out_locked_reg  <= item_reg.locked;
            out_enabled_reg <= item_reg.enabled;
            out_event_reg   <= event_item_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vel_x         = $signed(out_res_reg.vel[0]);
    assign vel_y         = $signed(out_res_reg.vel[1]);
    assign vel_z         = $signed(out_res_reg.vel[2]);
    assign force_x       = $signed(out_res_reg.frc[0]);
    assign force_y       = $signed(out_res_reg.frc[1]);
    assign force_z       = $signed(out_res_reg.frc[2]);
    assign locked        = out_locked_reg;
    assign force_enabled = out_enabled_reg;
    assign button_change = out_event_reg;

endmodule

`default_nettype wire

// ===== hdl/hvf_checker.sv =====
// Port-level checks for the haptic velocity filter and force top level.
// Bound to haptic_velocity_filter_force_top; uses no package items.
`default_nettype none

module hvf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] vel_x,
    input wire logic signed [31:0] force_x,
    input wire logic signed [31:0] force_y,
    input wire logic signed [31:0] force_z,
    input wire logic               force_enabled
);

    // A stalled result word holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vel_x) && $stable(force_x))
        else $error("stalled result word changed");

    // The sequencer is busy right after a word is taken in.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after acceptance");

    // A tick keeps the block busy, so in_ready is still low well into it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##8 !in_ready)
        else $error("input ready too early in a tick");

    // With force output disabled every force field is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !force_enabled |-> force_x == 0 && force_y == 0 && force_z == 0)
        else $error("nonzero force while disabled");

endmodule

bind haptic_velocity_filter_force_top hvf_checker u_hvf_checker (.*);

`default_nettype wire

// ===== tb/sv/hvf_tb_pkg.sv =====
// Scoreboard for the haptic velocity filter and force testbench: word types, a bit-exact
// predictor of filtered velocity, button flags and motor force, and the result check.
// Depends on hvf_pkg for the block's widths.
package hvf_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import hvf_pkg::*;

    typedef logic signed [POS_W-1:0] word_t;

    typedef struct {
        word_t pos [AXES];
        logic  grey;
        logic  white;
        word_t cmd [AXES];
        word_t tgt [AXES];
    } tick_in_t;

    typedef struct {
        word_t vel [AXES];
        word_t frc [AXES];
        logic  locked;
        logic  enabled;
        logic  btn_evt;
    } tick_out_t;

    localparam longint COEF_B0  = 64'sd235794;
    localparam longint COEF_B1  = 64'sd707381;
    localparam longint COEF_A1  = 64'sd2951501526;
    localparam longint COEF_A2  = -64'sd2714634079;
    localparam longint COEF_A3  = 64'sd834941642;
    localparam longint DAMP_K   = 64'sd1073742;
    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint HALF_RND = 64'sd536870912;
    localparam longint SPRING_K [4] = '{64'sd42949673, 64'sd4294967, 64'sd429497,
                                        64'sd42950};

    class force_scoreboard;
        bit [1:0]  units;
        longint    pos_one [AXES];
        longint    pos_two [AXES];
        longint    raw_taps [AXES][3];
        longint    filt_taps [AXES][3];
        bit [1:0]  prev_btn;
        bit        lock_on;
        bit        force_on;
        tick_out_t expected_q [$];
        int        errors;
        int        words_in;
        int        words_checked;
        int        ticks_locked;
        int        ticks_disabled;
        int        btn_events;

        function new();
            force_on = 1'b1;
        endfunction

        static function longint clip(longint v, int bits);
            longint hi;
            hi = (64'sd1 <<< (bits - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(tick_in_t t);
            tick_out_t e;
            longint    xs [4];
            longint    cx [4];
            longint    cy [3];
            longint    p, tg, cm, d, y, yprev, f, tap, cf, lo, acc_hi, acc_lo, spring;
            bit [1:0]  cur;
            bit        evt;
            cx = '{COEF_B0, COEF_B1, COEF_B1, COEF_B0};
            cy = '{COEF_A1, COEF_A2, COEF_A3};
            cur = {t.white, t.grey};
            evt = cur != prev_btn;
            spring = SPRING_K[units];
            for (int a = 0; a < AXES; a++)
            begin
                p  = t.pos[a];
                tg = t.tgt[a];
                cm = t.cmd[a];
                d = 3 * p - 4 * pos_one[a] + pos_two[a];
                xs[0] = clip(d * 500, TAP_W);
                xs[1] = raw_taps[a][0];
                xs[2] = raw_taps[a][1];
                xs[3] = raw_taps[a][2];
                acc_hi = 0;
                acc_lo = 0;
                for (int k = 0; k < 7; k++)
                begin
                    tap = (k < 4) ? xs[k] : filt_taps[a][k - 4];
                    cf  = (k < 4) ? cx[k] : cy[k - 4];
                    lo  = tap & 64'hFFFF;
                    acc_hi += cf * (tap >>> LO_W);
                    acc_lo += cf * lo;
                end
                y = clip((acc_hi + ((acc_lo + HALF_RND) >>> LO_W)) >>> (RND_SH - LO_W), TAP_W);
                yprev = filt_taps[a][0];

                pos_two[a] = pos_one[a];
                pos_one[a] = p;
                raw_taps[a][2] = raw_taps[a][1];
                raw_taps[a][1] = raw_taps[a][0];
                raw_taps[a][0] = xs[0];
                filt_taps[a][2] = filt_taps[a][1];
                filt_taps[a][1] = yprev;
                filt_taps[a][0] = y;

                if (lock_on)
                    f = (tg - p) * spring - DAMP_K * y;
                else
                    f = cm * ONE_Q30 - DAMP_K * yprev;
                f = clip((f + HALF_RND) >>> RND_SH, POS_W);
                if (!force_on)
                    f = 0;
                e.vel[a] = word_t'(clip(y, POS_W));
                e.frc[a] = word_t'(f);
            end
            e.locked  = lock_on;
            e.enabled = force_on;
            e.btn_evt = evt;
            if (lock_on)
                ticks_locked++;
            if (!force_on)
                ticks_disabled++;
            if (evt)
            begin
                btn_events++;
                if (cur[0])
                    force_on = !force_on;
                if (cur[1])
                    lock_on = !lock_on;
                prev_btn = cur;
            end
            expected_q.push_back(e);
            words_in++;
        endfunction

        function void report_miss(string field, word_t exp_v, word_t act_v);
            $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_v, act_v);
            errors++;
        endfunction

        function void check(tick_out_t got);
            tick_out_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t ns: result word with nothing expected, vel %0d %0d %0d",
                         $time, got.vel[0], got.vel[1], got.vel[2]);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            words_checked++;
            for (int a = 0; a < AXES; a++)
            begin
                if (got.vel[a] !== e.vel[a])
                    report_miss($sformatf("vel[%0d]", a), e.vel[a], got.vel[a]);
                if (got.frc[a] !== e.frc[a])
                    report_miss($sformatf("force[%0d]", a), e.frc[a], got.frc[a]);
            end
            if (got.locked !== e.locked)
                report_miss("locked", e.locked, got.locked);
            if (got.enabled !== e.enabled)
                report_miss("force_enabled", e.enabled, got.enabled);
            if (got.btn_evt !== e.btn_evt)
                report_miss("button_change", e.btn_evt, got.btn_evt);
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top of the haptic velocity filter and force testbench: clock, reset, word driver,
// result receiver with random stalls, unit-select phases and a handshake watchdog.
// Depends on hvf_tb_pkg for the scoreboard and on the block haptic_velocity_filter_force_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hvf_tb_pkg::*;

    localparam int    STALL_LIMIT = 2000;
    localparam word_t MAXW        = 32'h7FFF_FFFF;
    localparam word_t MINW        = 32'h8000_0000;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_wr_data   = 2'd0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    word_t       pos_x         = '0;
    word_t       pos_y         = '0;
    word_t       pos_z         = '0;
    logic        button_grey   = 1'b0;
    logic        button_white  = 1'b0;
    word_t       cmd_force_x   = '0;
    word_t       cmd_force_y   = '0;
    word_t       cmd_force_z   = '0;
    word_t       lock_target_x = '0;
    word_t       lock_target_y = '0;
    word_t       lock_target_z = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    word_t       vel_x, vel_y, vel_z;
    word_t       force_x, force_y, force_z;
    logic        locked, force_enabled, button_change;

    force_scoreboard sb = new();
    bit              calm = 1'b0;
    int              rx_hold = 0;
    int              quiet = 0;
    bit [1:0]        btn_state = 2'd0;
    word_t           traj [3] = '{default: '0};
    bit [1:0]        unit_plan [4] = '{2'd3, 2'd1, 2'd2, 2'd0};

    haptic_velocity_filter_force_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .button_grey   (button_grey),
        .button_white  (button_white),
        .cmd_force_x   (cmd_force_x),
        .cmd_force_y   (cmd_force_y),
        .cmd_force_z   (cmd_force_z),
        .lock_target_x (lock_target_x),
        .lock_target_y (lock_target_y),
        .lock_target_z (lock_target_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .force_x       (force_x),
        .force_y       (force_y),
        .force_z       (force_z),
        .locked        (locked),
        .force_enabled (force_enabled),
        .button_change (button_change)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic tick_in_t mk(word_t p, bit g, bit w, word_t c, word_t tg);
        tick_in_t t;
        t.pos[0] = p;
        t.pos[1] = ~p;
        t.pos[2] = p >>> 3;
        t.grey   = g;
        t.white  = w;
        t.cmd[0] = c;
        t.cmd[1] = -c;
        t.cmd[2] = c >>> 5;
        t.tgt[0] = tg;
        t.tgt[1] = ~tg;
        t.tgt[2] = tg >>> 2;
        return t;
    endfunction

    function automatic word_t extreme();
        case ($urandom_range(0, 4))
            0:       return MAXW;
            1:       return MINW;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic word_t nudge(int bits);
        return word_t'($urandom_range(0, (1 << (bits + 1)) - 1)) - word_t'(1 << bits);
    endfunction

    function automatic tick_in_t next_tick();
        tick_in_t t;
        int       r;
        if ($urandom_range(0, 7) == 0)
            btn_state = 2'($urandom);
        t.grey  = btn_state[0];
        t.white = btn_state[1];
        for (int a = 0; a < 3; a++)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                traj[a] = traj[a] + nudge(20);
            else if (r < 88)
                traj[a] = word_t'($urandom);
            else
                traj[a] = extreme();
            t.pos[a] = traj[a];
            r = $urandom_range(0, 99);
            t.cmd[a] = (r < 60) ? nudge(18) : ((r < 85) ? word_t'($urandom) : extreme());
            r = $urandom_range(0, 99);
            t.tgt[a] = (r < 60) ? traj[a] + nudge(22)
                                : ((r < 80) ? word_t'($urandom) : extreme());
        end
        return t;
    endfunction

    task automatic send_word(tick_in_t t);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 15) ? $urandom_range(1, 120) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        pos_x         <= t.pos[0];
        pos_y         <= t.pos[1];
        pos_z         <= t.pos[2];
        button_grey   <= t.grey;
        button_white  <= t.white;
        cmd_force_x   <= t.cmd[0];
        cmd_force_y   <= t.cmd[1];
        cmd_force_z   <= t.cmd[2];
        lock_target_x <= t.tgt[0];
        lock_target_y <= t.tgt[1];
        lock_target_z <= t.tgt[2];
        do @(posedge clk); while (!in_ready);
        sb.note_input(t);
    endtask

    task automatic hold_off();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_units(bit [1:0] u);
        hold_off();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= u;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.units = u;
    endtask

    always @(posedge clk)
    begin
        tick_out_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.vel[0]  = vel_x;
            got.vel[1]  = vel_y;
            got.vel[2]  = vel_z;
            got.frc[0]  = force_x;
            got.frc[1]  = force_y;
            got.frc[2]  = force_z;
            got.locked  = locked;
            got.enabled = force_enabled;
            got.btn_evt = button_change;
            sb.check(got);
        end
        if (calm)
            out_ready <= 1'b1;
        else if (rx_hold > 0)
        begin
            rx_hold   = rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 1)
        begin
            rx_hold   = $urandom_range(0, 20);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == STALL_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, quiet);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(mk('0, 0, 0, '0, '0));
        send_word(mk(MAXW, 0, 0, MAXW, '0));
        send_word(mk(MINW, 0, 0, MINW, '0));
        send_word(mk(MAXW, 0, 0, MAXW, MINW));
        send_word(mk(MINW, 0, 0, MINW, MAXW));
        send_word(mk('0, 0, 0, 1, '0));
        send_word(mk('0, 1, 0, MAXW, '0));
        send_word(mk('0, 1, 0, MAXW, '0));
        send_word(mk('0, 0, 0, MINW, '0));
        send_word(mk('0, 1, 0, MINW, '0));
        send_word(mk('0, 0, 1, MAXW, '0));
        send_word(mk('0, 0, 1, '0, MAXW));
        send_word(mk(MINW, 0, 0, '0, MAXW));
        send_word(mk(MAXW, 0, 0, '0, MINW));
        send_word(mk(MINW, 1, 1, MAXW, MAXW));
        send_word(mk('0, 0, 0, MAXW, '0));
        send_word(mk(1, 1, 1, -1, -1));
        send_word(mk(-1, 0, 0, '0, MINW));
        send_word(mk(MAXW, 0, 1, '0, MINW));
        send_word(mk('0, 0, 0, 1, 1));

        for (int ph = 0; ph < 4; ph++)
        begin
            set_units(unit_plan[ph]);
            for (int i = 0; i < 135; i++)
            begin
                calm = (ph == 1 && i >= 20 && i < 110);
                send_word(next_tick());
            end
            calm = 1'b0;
        end

        hold_off();
        repeat (200) @(posedge clk);

        $display("Drove %0d words and checked %0d results over unit selects 0 to 3.",
                 sb.words_in, sb.words_checked);
        $display("Ticks locked %0d, force off %0d, button events %0d, mismatches %0d.",
                 sb.ticks_locked, sb.ticks_disabled, sb.btn_events, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
